@@ hdl/mie_pkg.sv @@
// ----------------------------------------------------------------------------
// mie_pkg: shared constants for the modular inverse block
// Default word width for the channel interfaces and the guard bits that the
// Bezout coefficient registers carry above the word width.
// ----------------------------------------------------------------------------
package mie_pkg;

  // Default width of the value, modulus and inverse fields
  localparam int unsigned DEFAULT_WIDTH = 31;

  // Extra bits on the coefficient registers: sign plus one bit of headroom
  localparam int unsigned COEF_GUARD_BITS = 2;

endpackage

@@ hdl/mie_if.sv @@
// ----------------------------------------------------------------------------
// mie_req_if / mie_rsp_if: request and response channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface mie_req_if #(
  parameter int unsigned WIDTH = mie_pkg::DEFAULT_WIDTH
) ();
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] value;
  logic [WIDTH-1:0] modulus;

  modport source (output valid, output value, output modulus, input ready);
  modport sink   (input valid, input value, input modulus, output ready);
endinterface

interface mie_rsp_if #(
  parameter int unsigned WIDTH = mie_pkg::DEFAULT_WIDTH
) ();
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] inverse;
  logic             no_inverse;

  modport source (output valid, output inverse, output no_inverse, input ready);
  modport sink   (input valid, input inverse, input no_inverse, output ready);
endinterface

@@ hdl/modular_inverse_extended_euclid.sv @@
// ----------------------------------------------------------------------------
// modular_inverse_extended_euclid: modular inverse by extended Euclid
// Shift-and-subtract division drives the remainder and coefficient updates.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries a value and a modulus; rsp_o returns the inverse of the
//   value modulo the modulus, or 0 with no_inverse set when the two share a
//   factor, the value is zero or the modulus is zero. A modulus of one gives
//   0 with no_inverse clear.
//   One word is worked on at a time; req_i.ready is high only while idle.
//   Each Euclid step finds its quotient one bit per cycle on a single
//   subtract/compare unit: a check state, an alignment state that grows
//   the divisor shift until it would pass the remainder, and a subtract
//   state that forms the quotient bits from the top down. The time a word
//   takes from acceptance to result is set by the number of Euclid steps
//   and quotient bits; the block returns to idle before the next request.
//   The result sits in an output register; a new request is taken while it
//   waits. If the receiver stalls, the block holds its next result until
//   the register frees up, and does not take new requests meanwhile.
//   Reset clears the sequencer and the output valid; no word is in flight.
// ----------------------------------------------------------------------------
module modular_inverse_extended_euclid #(
  parameter int unsigned WIDTH = 31
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mie_req_if.sink   req_i,
  mie_rsp_if.source rsp_o
);

  localparam int unsigned TW = WIDTH + mie_pkg::COEF_GUARD_BITS;
  localparam int unsigned KW = $clog2(WIDTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ALIGN,
    ST_SUB,
    ST_FINISH
  } state_e;

  state_e           state_q;
  logic [WIDTH-1:0] a_q;      // previous remainder, becomes running remainder
  logic [WIDTH-1:0] b_q;      // current remainder (divisor)
  logic [WIDTH-1:0] m_q;      // modulus
  logic [TW-1:0]    ta_q;     // coefficient paired with a_q, wraps mod 2^TW
  logic [TW-1:0]    tb_q;     // coefficient paired with b_q
  logic [KW-1:0]    k_q;      // quotient bit position
  logic             rsp_valid_q;
  logic [WIDTH-1:0] rsp_inv_q;
  logic             rsp_flag_q;

  logic [WIDTH:0]   shl_b;
  logic [WIDTH:0]   shl_b2;
  logic             align_go;
  logic [WIDTH-1:0] sub_d;
  logic             sub_ok;
  logic [WIDTH-1:0] a_rem;
  logic [TW-1:0]    tb_shl;
  logic [TW-1:0]    ta_new;
  logic [TW-1:0]    t_fix;
  logic [WIDTH-1:0] inv_val;
  logic             nflag;

  // Shared shift / compare / subtract unit
  always_comb begin
    shl_b    = {1'b0, b_q} << k_q;
    shl_b2   = {shl_b[WIDTH-1:0], 1'b0};
    align_go = shl_b2 <= {1'b0, a_q};
    sub_d    = shl_b[WIDTH-1:0];
    sub_ok   = sub_d <= a_q;
    a_rem    = sub_ok ? (a_q - sub_d) : a_q;
    tb_shl   = tb_q << k_q;
    ta_new   = sub_ok ? (ta_q - tb_shl) : ta_q;
  end

  // Final fix-up: negative coefficient folds into 0..m-1
  // modulus of one: every residue is 0, so the inverse is 0
  always_comb begin
    t_fix   = ta_q + {{mie_pkg::COEF_GUARD_BITS{1'b0}}, m_q};
    inv_val = (m_q == {{(WIDTH-1){1'b0}}, 1'b1}) ? '0 :
              (ta_q[TW-1] ? t_fix[WIDTH-1:0] : ta_q[WIDTH-1:0]);
    nflag   = (a_q != {{(WIDTH-1){1'b0}}, 1'b1}) || (m_q == '0);
  end

  assign req_i.ready      = (state_q == ST_IDLE);
  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.inverse    = rsp_inv_q;
  assign rsp_o.no_inverse = rsp_flag_q;

  // Sequencer, datapath registers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      // in ST_FINISH the output register is reloaded below instead
      if (rsp_valid_q && rsp_o.ready && (state_q != ST_FINISH)) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (req_i.valid) begin
            a_q     <= req_i.modulus;
            b_q     <= req_i.value;
            m_q     <= req_i.modulus;
            ta_q    <= '0;
            tb_q    <= {{(TW-1){1'b0}}, 1'b1};
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          k_q     <= '0;
          state_q <= (b_q == '0) ? ST_FINISH : ST_ALIGN;
        end
        ST_ALIGN: begin
          // grow the divisor shift while it still fits under the remainder
          if (align_go) begin
            k_q <= k_q + KW'(1);
          end else begin
            state_q <= ST_SUB;
          end
        end
        ST_SUB: begin
          if (k_q == '0) begin
            // last quotient bit: rotate into the next Euclid step
            a_q     <= b_q;
            b_q     <= a_rem;
            ta_q    <= tb_q;
            tb_q    <= ta_new;
            state_q <= ST_CHECK;
          end else begin
            a_q  <= a_rem;
            ta_q <= ta_new;
            k_q  <= k_q - KW'(1);
          end
        end
        ST_FINISH: begin
          if (!rsp_valid_q || rsp_o.ready) begin
            rsp_valid_q <= 1'b1;
            rsp_inv_q   <= nflag ? '0 : inv_val;
            rsp_flag_q  <= nflag;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Divisor is never zero while a quotient is being formed
  a_nonzero_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ALIGN || state_q == ST_SUB) |-> (b_q != '0))
    else $error("zero divisor during division");

  // A flagged result always carries a zero inverse
  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_flag_q) |-> (rsp_inv_q == '0))
    else $error("no_inverse set with nonzero inverse");

  // After taking a request the block is busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request taken while still working");

endmodule
